// ----- hdl/pfd_pkg.sv -----
// Shared types, constants and lookup functions for the Playfair pair decryptor.
`default_nettype none

package pfd_pkg;

  // Square geometry and letter code width.
  localparam int GRID_SIDE      = 5;
  localparam int CODE_BITS      = 5;
  localparam int ROW_BITS       = GRID_SIDE * CODE_BITS;
  localparam int IDX_BITS       = $clog2(GRID_SIDE);
  localparam int CFG_INDEX_BITS = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_KEY_ROW_0 = 3'd0,
    CFG_KEY_ROW_1 = 3'd1,
    CFG_KEY_ROW_2 = 3'd2,
    CFG_KEY_ROW_3 = 3'd3,
    CFG_KEY_ROW_4 = 3'd4
  } cfg_reg_e;

  typedef logic [CODE_BITS-1:0] code_t;
  typedef logic [IDX_BITS-1:0]  idx_t;

  // Key square: row r, column c sits in grid[r][5c+4:5c].
  typedef logic [GRID_SIDE-1:0][ROW_BITS-1:0] grid_t;

  // Position of one letter in the square.
  typedef struct packed {
    logic found;
    idx_t row;
    idx_t col;
  } loc_t;

  // Classified item passed from the front to the back.
  typedef struct packed {
    loc_t loc_a;
    loc_t loc_b;
  } pair_loc_t;

  // Result item.
  typedef struct packed {
    code_t plain_first;
    code_t plain_second;
    logic  letter_missing;
  } result_t;

  // Finds the first match in row-major order; scanning backwards lets the
  // earliest cell overwrite later ones.
  function automatic loc_t locate(code_t code, grid_t grid);
    loc_t res;
    res = '0;
    for (int r = GRID_SIDE - 1; r >= 0; r--) begin
      for (int c = GRID_SIDE - 1; c >= 0; c--) begin
        if (grid[r][c*CODE_BITS +: CODE_BITS] == code) begin
          res.found = 1'b1;
          res.row   = IDX_BITS'(r);
          res.col   = IDX_BITS'(c);
        end
      end
    end
    return res;
  endfunction

  // Reads the letter at one cell.
  function automatic code_t cell_at(grid_t grid, idx_t row, idx_t col);
    return grid[row][col*CODE_BITS +: CODE_BITS];
  endfunction

  // One step left or up, wrapping at the edge.
  function automatic idx_t step_back(idx_t v);
    return (v == '0) ? IDX_BITS'(GRID_SIDE - 1) : v - 1'b1;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/pfd_fifo.sv -----
// Small register-based queue with combinational head read.
`default_nettype none

module pfd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full    = (count == CNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // Storage is written only when there is room.
  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en && !empty) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en && !full, rd_en && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pfd_front.sv -----
// Front part: takes a ciphertext pair and locates both letters in the square.
`default_nettype none

module pfd_front (
  input  wire logic              push,
  input  wire pfd_pkg::code_t    first_cipher,
  input  wire pfd_pkg::code_t    second_cipher,
  input  wire pfd_pkg::grid_t    grid,
  input  wire logic              queue_full,
  output logic                   full,
  output logic                   queue_wr,
  output pfd_pkg::pair_loc_t     queue_data
);

  // An item is taken whenever the middle queue has room.
  assign full     = queue_full;
  assign queue_wr = push && !queue_full;

  // Parallel compare against all cells, first match wins.
  always_comb begin
    queue_data.loc_a = pfd_pkg::locate(first_cipher, grid);
    queue_data.loc_b = pfd_pkg::locate(second_cipher, grid);
  end

endmodule

`default_nettype wire

// ----- hdl/pfd_back.sv -----
// Back part: applies the Playfair decryption rules to a located pair.
`default_nettype none

module pfd_back (
  input  wire pfd_pkg::grid_t     grid,
  input  wire logic               queue_empty,
  input  wire pfd_pkg::pair_loc_t queue_data,
  input  wire logic               out_full,
  output logic                    queue_rd,
  output logic                    out_wr,
  output pfd_pkg::result_t        out_data
);

  pfd_pkg::loc_t a;
  pfd_pkg::loc_t b;

  assign a = queue_data.loc_a;
  assign b = queue_data.loc_b;

  // Move one item per cycle when the result queue has room.
  assign queue_rd = !queue_empty && !out_full;
  assign out_wr   = queue_rd;

  // A missing letter sets the flag; same row shifts left, same column shifts up, otherwise columns swap.
  always_comb begin
    out_data = '0;
    if (!a.found || !b.found) begin
      out_data.letter_missing = 1'b1;
    end else if (a.row == b.row) begin
      out_data.plain_first  = pfd_pkg::cell_at(grid, a.row, pfd_pkg::step_back(a.col));
      out_data.plain_second = pfd_pkg::cell_at(grid, b.row, pfd_pkg::step_back(b.col));
    end else if (a.col == b.col) begin
      out_data.plain_first  = pfd_pkg::cell_at(grid, pfd_pkg::step_back(a.row), a.col);
      out_data.plain_second = pfd_pkg::cell_at(grid, pfd_pkg::step_back(b.row), b.col);
    end else begin
      out_data.plain_first  = pfd_pkg::cell_at(grid, a.row, b.col);
      out_data.plain_second = pfd_pkg::cell_at(grid, b.row, a.col);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/playfair_pair_decrypt.sv -----
// Top level of the Playfair pair decryptor: key registers, front, queues and back.
// An item pushed is located into the middle queue, decrypted into the result queue
// and shown at its head. Throughput: one item per cycle while results are popped,
// set by the single located-pair move from the middle to the result queue.
// Reset: synchronous rst empties both queues and clears every key row to zero.
`default_nettype none

module playfair_pair_decrypt #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic [pfd_pkg::CODE_BITS-1:0]        first_cipher,
  input  wire logic [pfd_pkg::CODE_BITS-1:0]        second_cipher,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic      [pfd_pkg::CODE_BITS-1:0]        plain_first,
  output logic      [pfd_pkg::CODE_BITS-1:0]        plain_second,
  output logic                                      letter_missing,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [pfd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [pfd_pkg::ROW_BITS-1:0]         cfg_data
);

  pfd_pkg::grid_t     grid;
  logic               mid_wr;
  logic               mid_rd;
  logic               mid_full;
  logic               mid_empty;
  pfd_pkg::pair_loc_t mid_wr_data;
  pfd_pkg::pair_loc_t mid_rd_data;
  logic               out_wr;
  logic               out_full;
  pfd_pkg::result_t   out_wr_data;
  pfd_pkg::result_t   out_rd_data;

  // Key rows accept a write in any cycle; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pfd_pkg::cfg_reg_e'(cfg_index))
        pfd_pkg::CFG_KEY_ROW_0: grid[0] <= cfg_data;
        pfd_pkg::CFG_KEY_ROW_1: grid[1] <= cfg_data;
        pfd_pkg::CFG_KEY_ROW_2: grid[2] <= cfg_data;
        pfd_pkg::CFG_KEY_ROW_3: grid[3] <= cfg_data;
        pfd_pkg::CFG_KEY_ROW_4: grid[4] <= cfg_data;
        default: grid <= grid;
      endcase
    end
  end

  // Front part locates both letters.
  pfd_front u_front (
    .push          (push),
    .first_cipher  (first_cipher),
    .second_cipher (second_cipher),
    .grid          (grid),
    .queue_full    (mid_full),
    .full          (full),
    .queue_wr      (mid_wr),
    .queue_data    (mid_wr_data)
  );

  // Queue between the front and the back.
  pfd_fifo #(
    .WIDTH ($bits(pfd_pkg::pair_loc_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_wr),
    .wr_data (mid_wr_data),
    .rd_en   (mid_rd),
    .rd_data (mid_rd_data),
    .full    (mid_full),
    .empty   (mid_empty)
  );

  // Back part produces the plaintext pair.
  pfd_back u_back (
    .grid        (grid),
    .queue_empty (mid_empty),
    .queue_data  (mid_rd_data),
    .out_full    (out_full),
    .queue_rd    (mid_rd),
    .out_wr      (out_wr),
    .out_data    (out_wr_data)
  );

  // Result queue seen by the consumer.
  pfd_fifo #(
    .WIDTH ($bits(pfd_pkg::result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_wr),
    .wr_data (out_wr_data),
    .rd_en   (pop),
    .rd_data (out_rd_data),
    .full    (out_full),
    .empty   (empty)
  );

  assign plain_first    = out_rd_data.plain_first;
  assign plain_second   = out_rd_data.plain_second;
  assign letter_missing = out_rd_data.letter_missing;

endmodule

`default_nettype wire

// ----- hdl/pfd_checker.sv -----
// Port-level checks for the Playfair pair decryptor, bound to the top level.
`default_nettype none

module pfd_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               full,
  input wire logic                               empty,
  input wire logic                               pop,
  input wire logic [pfd_pkg::CODE_BITS-1:0]      plain_first,
  input wire logic [pfd_pkg::CODE_BITS-1:0]      plain_second,
  input wire logic                               letter_missing
);

  // A waiting result item stays until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("result item withdrawn before it was taken");

  // A waiting result item keeps its value.
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> $stable(plain_first) && $stable(plain_second)
                       && $stable(letter_missing))
    else $error("result item changed while waiting");

  // A missing letter gives zero plaintext codes.
  a_missing_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && letter_missing |-> plain_first == '0 && plain_second == '0)
    else $error("missing-letter item carries non-zero codes");

  // Reset leaves the result queue empty and the middle queue not full.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("queues not empty after reset");

endmodule

bind playfair_pair_decrypt pfd_checker u_pfd_checker (.*);

`default_nettype wire

// ----- test/tb_playfair_pair_decrypt.sv -----
// Self-checking testbench for the Playfair pair decryptor: scripted, then random pairs.
`default_nettype none

module tb_playfair_pair_decrypt;

  localparam int GRID_SIDE          = pfd_pkg::GRID_SIDE;
  localparam int CODE_BITS          = pfd_pkg::CODE_BITS;
  localparam int ROW_BITS           = pfd_pkg::ROW_BITS;
  localparam int CFG_INDEX_BITS     = pfd_pkg::CFG_INDEX_BITS;
  localparam int QUIET_LIMIT        = 1000;
  localparam int RANDOM_PHASES      = 6;
  localparam int PAIRS_PER_PHASE    = 67;
  localparam int REPORT_LIMIT       = 10;
  localparam int FIRST_UNUSED_INDEX = int'(pfd_pkg::CFG_KEY_ROW_4) + 1;
  localparam int LAST_INDEX         = (1 << CFG_INDEX_BITS) - 1;
  localparam logic [ROW_BITS-1:0] ROW_ALL_ONES = '1;
  localparam pfd_pkg::result_t LETTER_ABSENT =
    '{plain_first: '0, plain_second: '0, letter_missing: 1'b1};

  // Kinds of line in the scripted opening.
  typedef enum logic [1:0] {
    STEP_WRITE,
    STEP_PAIR,
    STEP_PAIR_KNOWN
  } step_kind_e;

  // Square fillings used by the random phases.
  typedef enum int {
    SQUARE_DISTINCT,
    SQUARE_CROWDED,
    SQUARE_NOISE,
    SQUARE_STRIPES
  } square_style_e;

  // Receiver stall patterns.
  typedef enum int {
    DRAIN_FREE,
    DRAIN_COIN,
    DRAIN_SPARSE,
    DRAIN_LONG_STALL
  } drain_mode_e;

  typedef struct packed {
    step_kind_e                 kind;
    logic [CFG_INDEX_BITS-1:0]  index;
    logic [ROW_BITS-1:0]        data;
    pfd_pkg::code_t             first;
    pfd_pkg::code_t             second;
    pfd_pkg::result_t           want;
  } script_step_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       push = 1'b0;
  logic                       full;
  logic [CODE_BITS-1:0]       first_cipher = '0;
  logic [CODE_BITS-1:0]       second_cipher = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic [CODE_BITS-1:0]       plain_first;
  logic [CODE_BITS-1:0]       plain_second;
  logic                       letter_missing;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
  logic [ROW_BITS-1:0]        cfg_data = '0;

  // Shadow copy of the key square, expected results and bookkeeping.
  logic [ROW_BITS-1:0] key_rows [GRID_SIDE];
  pfd_pkg::result_t    plain_pairs_due [$];
  script_step_t        decrypt_script [$];
  pfd_pkg::result_t    due;
  int                  mismatch_count = 0;
  int                  quiet_cycles = 0;
  int                  burst_left = 0;
  int                  drain_count = 0;
  drain_mode_e         drain_mode = DRAIN_FREE;

  playfair_pair_decrypt u_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .first_cipher   (first_cipher),
    .second_cipher  (second_cipher),
    .empty          (empty),
    .pop            (pop),
    .plain_first    (plain_first),
    .plain_second   (plain_second),
    .letter_missing (letter_missing),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  // Letter held at one cell of the shadow square.
  function automatic pfd_pkg::code_t square_cell(int row, int col);
    return key_rows[row][col*CODE_BITS +: CODE_BITS];
  endfunction

  // First match in row-major order.
  function automatic logic find_letter(input pfd_pkg::code_t code, output int row,
                                       output int col);
    logic hit;
    hit = 1'b0;
    row = 0;
    col = 0;
    for (int r = 0; r < GRID_SIDE; r++) begin
      for (int c = 0; c < GRID_SIDE; c++) begin
        if (!hit && square_cell(r, c) == code) begin
          hit = 1'b1;
          row = r;
          col = c;
        end
      end
    end
    return hit;
  endfunction

  // Plaintext pair for one ciphertext pair under the shadow square.
  function automatic pfd_pkg::result_t expected_plain(pfd_pkg::code_t a, pfd_pkg::code_t b);
    int               r1, c1, r2, c2;
    logic             hit_a, hit_b;
    pfd_pkg::result_t res;
    hit_a = find_letter(a, r1, c1);
    hit_b = find_letter(b, r2, c2);
    res = '0;
    if (!hit_a || !hit_b) begin
      res.letter_missing = 1'b1;
    end else if (r1 == r2) begin
      res.plain_first  = square_cell(r1, (c1 + GRID_SIDE - 1) % GRID_SIDE);
      res.plain_second = square_cell(r2, (c2 + GRID_SIDE - 1) % GRID_SIDE);
    end else if (c1 == c2) begin
      res.plain_first  = square_cell((r1 + GRID_SIDE - 1) % GRID_SIDE, c1);
      res.plain_second = square_cell((r2 + GRID_SIDE - 1) % GRID_SIDE, c2);
    end else begin
      res.plain_first  = square_cell(r1, c2);
      res.plain_second = square_cell(r2, c1);
    end
    return res;
  endfunction

  // Row r of the plain alphabet square: codes 5r to 5r+4.
  function automatic logic [ROW_BITS-1:0] alphabet_row(int r);
    logic [ROW_BITS-1:0] row;
    for (int c = 0; c < GRID_SIDE; c++)
      row[c*CODE_BITS +: CODE_BITS] = CODE_BITS'(r * GRID_SIDE + c);
    return row;
  endfunction

  function automatic void add_write(int index, logic [ROW_BITS-1:0] data);
    decrypt_script.push_back('{STEP_WRITE, CFG_INDEX_BITS'(index), data, '0, '0, '0});
  endfunction

  function automatic void add_pair(pfd_pkg::code_t a, pfd_pkg::code_t b);
    decrypt_script.push_back('{STEP_PAIR, '0, '0, a, b, '0});
  endfunction

  function automatic void add_known(pfd_pkg::code_t a, pfd_pkg::code_t b,
                                    pfd_pkg::result_t want);
    decrypt_script.push_back('{STEP_PAIR_KNOWN, '0, '0, a, b, want});
  endfunction

  // Lowers push and lets the block drain before a register write.
  task automatic wait_idle();
    push <= 1'b0;
    while (plain_pairs_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_key_row(int index, logic [ROW_BITS-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_INDEX_BITS'(index);
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (index < GRID_SIDE) key_rows[index] = data;
  endtask

  // Offers one item in bursts with random gaps; leaves push high once accepted.
  task automatic feed_pair(pfd_pkg::code_t a, pfd_pkg::code_t b, pfd_pkg::result_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 40)
                                               : $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 25);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push          <= 1'b1;
    first_cipher  <= a;
    second_cipher <= b;
    do @(posedge clk); while (full !== 1'b0);
    plain_pairs_due.push_back(want);
  endtask

  // Picks pairs mostly from the square, biased towards shared rows and columns.
  task automatic random_pair();
    int             r1, c1, r2, c2, pick;
    pfd_pkg::code_t a, b;
    r1 = $urandom_range(0, GRID_SIDE - 1);
    c1 = $urandom_range(0, GRID_SIDE - 1);
    r2 = $urandom_range(0, GRID_SIDE - 1);
    c2 = $urandom_range(0, GRID_SIDE - 1);
    pick = $urandom_range(0, 19);
    if (pick < 5) r2 = r1;
    else if (pick < 10) c2 = c1;
    a = square_cell(r1, c1);
    b = square_cell(r2, c2);
    if (pick >= 17) a = CODE_BITS'($urandom_range(0, 31));
    if (pick == 16 || pick == 19) b = CODE_BITS'($urandom_range(0, 31));
    feed_pair(a, b, expected_plain(a, b));
  endtask

  // Fills the whole square in one style, plus a write to an unused index.
  task automatic load_square(square_style_e style);
    int                  pool [32];
    int                  j, tmp;
    logic [ROW_BITS-1:0] row;
    for (int i = 0; i < 32; i++) pool[i] = i;
    for (int i = 31; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = pool[i];
      pool[i] = pool[j];
      pool[j] = tmp;
    end
    for (int r = 0; r < GRID_SIDE; r++) begin
      for (int c = 0; c < GRID_SIDE; c++) begin
        case (style)
          SQUARE_DISTINCT: row[c*CODE_BITS +: CODE_BITS] = CODE_BITS'(pool[r*GRID_SIDE + c]);
          SQUARE_CROWDED:  row[c*CODE_BITS +: CODE_BITS] = CODE_BITS'($urandom_range(0, 7));
          default:         row[c*CODE_BITS +: CODE_BITS] = CODE_BITS'($urandom);
        endcase
      end
      if (style == SQUARE_STRIPES) row = (r % 2 == 0) ? ROW_ALL_ONES : '0;
      write_key_row(r, row);
    end
    write_key_row($urandom_range(FIRST_UNUSED_INDEX, LAST_INDEX), ROW_BITS'($urandom));
  endtask

  // Receiver: checks each accepted result and stalls on a changing pattern.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && empty === 1'b0) begin
        if (plain_pairs_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected result %0d %0d %0d", plain_first, plain_second, letter_missing);
        end else begin
          due = plain_pairs_due.pop_front();
          if (plain_first !== due.plain_first || plain_second !== due.plain_second ||
              letter_missing !== due.letter_missing) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("mismatch: expected first %0d second %0d missing %0d, got %0d %0d %0d",
                       due.plain_first, due.plain_second, due.letter_missing,
                       plain_first, plain_second, letter_missing);
          end
        end
      end
      drain_count++;
      if (drain_count % 48 == 0) drain_mode = drain_mode_e'($urandom_range(0, 3));
      case (drain_mode)
        DRAIN_FREE:   pop <= 1'b1;
        DRAIN_COIN:   pop <= ($urandom_range(0, 1) == 1);
        DRAIN_SPARSE: pop <= ($urandom_range(0, 3) == 0);
        default:      pop <= (drain_count % 16 == 0);
      endcase
    end
  end

  // Watchdog on cycles in which no item moves on any channel.
  always @(posedge clk) begin
    if ((push && full === 1'b0) || (pop && empty === 1'b0) || (cfg_valid && cfg_ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus: scripted opening, then random squares with random pairs.
  initial begin
    for (int r = 0; r < GRID_SIDE; r++) key_rows[r] = '0;

    // Square after reset holds only code 0; an unused index must not change that.
    add_known(5'd0, 5'd0, '{plain_first: '0, plain_second: '0, letter_missing: 1'b0});
    add_known(5'd1, 5'd0, LETTER_ABSENT);
    add_known(5'd0, 5'd31, LETTER_ABSENT);
    add_known(5'd31, 5'd31, LETTER_ABSENT);
    add_write(FIRST_UNUSED_INDEX, ROW_ALL_ONES);
    add_known(5'd31, 5'd31, LETTER_ABSENT);
    add_known(5'd0, 5'd0, '{plain_first: '0, plain_second: '0, letter_missing: 1'b0});
    // Plain alphabet square: shared row, wraps, shared column, rectangle, same letter.
    for (int r = 0; r < GRID_SIDE; r++) add_write(r, alphabet_row(r));
    add_pair(5'd1, 5'd2);
    add_pair(5'd0, 5'd4);
    add_pair(5'd7, 5'd17);
    add_pair(5'd2, 5'd22);
    add_pair(5'd0, 5'd24);
    add_pair(5'd13, 5'd13);
    add_known(5'd25, 5'd3, LETTER_ABSENT);
    add_known(5'd3, 5'd31, LETTER_ABSENT);
    // Top row all code 31 and a row of codes above 25: repeated cells and high codes.
    add_write(int'(pfd_pkg::CFG_KEY_ROW_0), ROW_ALL_ONES);
    add_write(int'(pfd_pkg::CFG_KEY_ROW_1), {5'd30, 5'd29, 5'd28, 5'd27, 5'd26});
    add_known(5'd31, 5'd31, '{plain_first: 5'd31, plain_second: 5'd31, letter_missing: 1'b0});
    add_pair(5'd31, 5'd26);
    add_pair(5'd26, 5'd30);
    add_pair(5'd27, 5'd12);
    add_pair(5'd29, 5'd24);
    add_known(5'd0, 5'd7, LETTER_ABSENT);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (decrypt_script[i]) begin
      case (decrypt_script[i].kind)
        STEP_WRITE:      write_key_row(decrypt_script[i].index, decrypt_script[i].data);
        STEP_PAIR_KNOWN: feed_pair(decrypt_script[i].first, decrypt_script[i].second,
                                   decrypt_script[i].want);
        default:         feed_pair(decrypt_script[i].first, decrypt_script[i].second,
                                   expected_plain(decrypt_script[i].first,
                                                  decrypt_script[i].second));
      endcase
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_square(square_style_e'(p % 4));
      for (int n = 0; n < PAIRS_PER_PHASE; n++) random_pair();
    end

    push <= 1'b0;
    while (plain_pairs_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
